// ===== design/jddm_pkg.sv =====
// ----------------------------------------------------------------------------
// jddm_pkg
// Shared types and constants for the joystick differential drive mixer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package jddm_pkg;

   // Fixed field widths of the configuration registers and the results.
   localparam int RADIUS_W = 10;
   localparam int SPEED_W  = 7;
   localparam int FS_W     = 11;

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_DEADZONE   = 2'd0;
   localparam logic [1:0] REG_MAX_SPEED  = 2'd1;
   localparam logic [1:0] REG_FULL_SCALE = 2'd2;

   // Motor direction codes.
   typedef enum logic [1:0] {
      DIR_STOP = 2'd0,
      DIR_FWD  = 2'd1,
      DIR_BACK = 2'd2
   } dir_type;

   // Control bits that travel with each item down the pipeline.
   typedef struct packed {
      logic valid;
      logic dead;
      logic neg_r;
      logic neg_l;
   } ctrl_type;

endpackage

`default_nettype wire

// ===== design/jddm_front.sv =====
// ----------------------------------------------------------------------------
// jddm_front
// Mixing, squaring, dead-zone test, numerator product and divisor select.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jddm_front
   import jddm_pkg::*;
#(
   parameter int AXIS_BITS = 11
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              take,
   input  wire  signed [AXIS_BITS-1:0]      stick_x,
   input  wire  signed [AXIS_BITS-1:0]      stick_y,
   input  wire         [2*RADIUS_W-1:0]     deadzone_sq,
   input  wire         [SPEED_W-1:0]        max_speed,
   input  wire         [FS_W-1:0]           full_scale,
   output ctrl_type                         dn_ctrl,
   output logic        [AXIS_BITS+SPEED_W:0] dn_num_r,
   output logic        [AXIS_BITS+SPEED_W:0] dn_num_l,
   output logic        [((AXIS_BITS+1 > FS_W) ? AXIS_BITS+1 : FS_W)-1:0] dn_divisor
);

   localparam int MAG_W = AXIS_BITS + 1;
   localparam int NUM_W = MAG_W + SPEED_W;
   localparam int DIV_W = (MAG_W > FS_W) ? MAG_W : FS_W;
   localparam int SQ_W  = 2 * AXIS_BITS - 1;
   localparam int ZC_W  = (2 * AXIS_BITS > 2 * RADIUS_W) ? 2 * AXIS_BITS : 2 * RADIUS_W;

   // First stage: mix, magnitude and squares.
   logic signed [AXIS_BITS+1:0]   x_ext, y_ext, right_mix, left_mix;
   logic signed [AXIS_BITS+1:0]   right_abs, left_abs;
   logic signed [2*AXIS_BITS-1:0] x_prod, y_prod;

   logic             a_valid_ff;
   logic [SQ_W-1:0]  x_sq_ff, y_sq_ff;
   logic [MAG_W-1:0] mag_r_ff, mag_l_ff;
   logic             neg_r_ff, neg_l_ff;

   assign x_ext     = (AXIS_BITS+2)'(stick_x);
   assign y_ext     = (AXIS_BITS+2)'(stick_y);
   assign right_mix = -y_ext - x_ext;
   assign left_mix  = x_ext - y_ext;
   assign right_abs = right_mix[AXIS_BITS+1] ? -right_mix : right_mix;
   assign left_abs  = left_mix[AXIS_BITS+1] ? -left_mix : left_mix;
   assign x_prod    = (2*AXIS_BITS)'(stick_x) * (2*AXIS_BITS)'(stick_x);
   assign y_prod    = (2*AXIS_BITS)'(stick_y) * (2*AXIS_BITS)'(stick_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= take;
      end
      x_sq_ff  <= x_prod[SQ_W-1:0];
      y_sq_ff  <= y_prod[SQ_W-1:0];
      mag_r_ff <= right_abs[MAG_W-1:0];
      mag_l_ff <= left_abs[MAG_W-1:0];
      neg_r_ff <= right_mix[AXIS_BITS+1];
      neg_l_ff <= left_mix[AXIS_BITS+1];
   end

   // Second stage: dead-zone compare, numerators and divisor.
   logic [ZC_W-1:0]  sq_sum;
   logic [MAG_W-1:0] mag_max;
   logic [DIV_W-1:0] fs_eff;
   ctrl_type         ctrl_in;
   logic [NUM_W-1:0] num_r_in, num_l_in;
   logic [DIV_W-1:0] divisor_in;
   ctrl_type         ctrl_ff;

   always_comb begin
      sq_sum  = ZC_W'(x_sq_ff) + ZC_W'(y_sq_ff);
      mag_max = (mag_l_ff > mag_r_ff) ? mag_l_ff : mag_r_ff;
      // A full scale of zero behaves as one.
      fs_eff  = (full_scale == '0) ? DIV_W'(1) : DIV_W'(full_scale);
      divisor_in = (DIV_W'(mag_max) > fs_eff) ? DIV_W'(mag_max) : fs_eff;
      num_r_in   = NUM_W'(mag_r_ff) * NUM_W'(max_speed);
      num_l_in   = NUM_W'(mag_l_ff) * NUM_W'(max_speed);
      ctrl_in.valid = a_valid_ff;
      ctrl_in.dead  = sq_sum < ZC_W'(deadzone_sq);
      ctrl_in.neg_r = neg_r_ff;
      ctrl_in.neg_l = neg_l_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.valid <= 1'b0;
      end else begin
         ctrl_ff.valid <= ctrl_in.valid;
      end
      ctrl_ff.dead  <= ctrl_in.dead;
      ctrl_ff.neg_r <= ctrl_in.neg_r;
      ctrl_ff.neg_l <= ctrl_in.neg_l;
      dn_num_r      <= num_r_in;
      dn_num_l      <= num_l_in;
      dn_divisor    <= divisor_in;
   end

   assign dn_ctrl = ctrl_ff;

endmodule

`default_nettype wire

// ===== design/jddm_div_cell.sv =====
// ----------------------------------------------------------------------------
// jddm_div_cell
// One restoring-division cell: settles one quotient bit for both motors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jddm_div_cell
   import jddm_pkg::*;
#(
   parameter int NUM_W   = 19,
   parameter int DIV_W   = 12,
   parameter int BIT_POS = 6
) (
   input  wire                 clock,
   input  wire                 reset,
   input  ctrl_type            up_ctrl,
   input  wire   [NUM_W-1:0]   up_rem_r,
   input  wire   [NUM_W-1:0]   up_rem_l,
   input  wire   [SPEED_W-1:0] up_quo_r,
   input  wire   [SPEED_W-1:0] up_quo_l,
   input  wire   [DIV_W-1:0]   up_divisor,
   output ctrl_type            dn_ctrl,
   output logic  [NUM_W-1:0]   dn_rem_r,
   output logic  [NUM_W-1:0]   dn_rem_l,
   output logic  [SPEED_W-1:0] dn_quo_r,
   output logic  [SPEED_W-1:0] dn_quo_l,
   output logic  [DIV_W-1:0]   dn_divisor
);

   localparam int CMP_W = (NUM_W > DIV_W + SPEED_W) ? NUM_W : DIV_W + SPEED_W;

   logic [CMP_W-1:0]   div_shift, diff_r, diff_l;
   logic               ge_r, ge_l;
   logic [NUM_W-1:0]   rem_r_in, rem_l_in;
   logic [SPEED_W-1:0] quo_r_in, quo_l_in;
   ctrl_type           ctrl_ff;

   always_comb begin
      div_shift = CMP_W'(up_divisor) << BIT_POS;
      ge_r      = CMP_W'(up_rem_r) >= div_shift;
      ge_l      = CMP_W'(up_rem_l) >= div_shift;
      diff_r    = CMP_W'(up_rem_r) - div_shift;
      diff_l    = CMP_W'(up_rem_l) - div_shift;
      rem_r_in  = ge_r ? diff_r[NUM_W-1:0] : up_rem_r;
      rem_l_in  = ge_l ? diff_l[NUM_W-1:0] : up_rem_l;
      quo_r_in  = up_quo_r;
      quo_l_in  = up_quo_l;
      quo_r_in[BIT_POS] = ge_r;
      quo_l_in[BIT_POS] = ge_l;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.valid <= 1'b0;
      end else begin
         ctrl_ff.valid <= up_ctrl.valid;
      end
      ctrl_ff.dead  <= up_ctrl.dead;
      ctrl_ff.neg_r <= up_ctrl.neg_r;
      ctrl_ff.neg_l <= up_ctrl.neg_l;
      dn_rem_r      <= rem_r_in;
      dn_rem_l      <= rem_l_in;
      dn_quo_r      <= quo_r_in;
      dn_quo_l      <= quo_l_in;
      dn_divisor    <= up_divisor;
   end

   assign dn_ctrl = ctrl_ff;

endmodule

`default_nettype wire

// ===== design/joystick_differential_drive_mixer.sv =====
// ----------------------------------------------------------------------------
// joystick_differential_drive_mixer
// Arcade-drive mixer: joystick sample in, speed and direction per motor out.
// ----------------------------------------------------------------------------
// Throughput is one item per clock cycle; busy is high only while reset is.
// The result strobe is registered through two front stages, seven divider
// cells (one quotient bit each) and the output register. The receiver cannot
// stall.
// Reset clears the pipeline and loads the registers with radius 30,
// max speed 100 and full scale 512.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module joystick_differential_drive_mixer
   import jddm_pkg::*;
#(
   parameter int AXIS_BITS = 11
) (
   input  wire                         clock,
   input  wire                         reset,
   // Input item channel.
   input  wire                         start,
   output logic                        busy,
   input  wire  signed [AXIS_BITS-1:0] req_stick_x,
   input  wire  signed [AXIS_BITS-1:0] req_stick_y,
   // Result channel.
   output logic                        rsp_valid,
   output logic        [SPEED_W-1:0]   rsp_right_speed,
   output logic        [1:0]           rsp_right_dir,
   output logic        [SPEED_W-1:0]   rsp_left_speed,
   output logic        [1:0]           rsp_left_dir,
   output logic                        rsp_in_deadzone,
   // Configuration port.
   input  wire                         psel,
   input  wire                         penable,
   input  wire                         pwrite,
   input  wire         [3:0]           paddr,
   input  wire         [31:0]          pwdata,
   output logic        [31:0]          prdata,
   output logic                        pready
);

   localparam int MAG_W = AXIS_BITS + 1;
   localparam int NUM_W = MAG_W + SPEED_W;
   localparam int DIV_W = (MAG_W > FS_W) ? MAG_W : FS_W;

   // ---------------------------------------------------------------------
   // Configuration registers. Writes land on the access phase; the index
   // comes from the word address, and the unused index is ignored.
   // ---------------------------------------------------------------------
   logic [RADIUS_W-1:0]   deadzone_ff;
   logic [SPEED_W-1:0]    max_speed_ff;
   logic [FS_W-1:0]       full_scale_ff;
   logic [2*RADIUS_W-1:0] deadzone_sq_ff;
   logic                  cfg_write;
   logic [1:0]            cfg_index;

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;
   assign cfg_index = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         deadzone_ff   <= RADIUS_W'(30);
         max_speed_ff  <= SPEED_W'(100);
         full_scale_ff <= FS_W'(512);
      end else if (cfg_write) begin
         unique case (cfg_index)
            REG_DEADZONE:   deadzone_ff   <= pwdata[RADIUS_W-1:0];
            REG_MAX_SPEED:  max_speed_ff  <= pwdata[SPEED_W-1:0];
            REG_FULL_SCALE: full_scale_ff <= pwdata[FS_W-1:0];
            default: ;
         endcase
      end
   end

   // The squared radius is kept in a register so that the dead-zone compare
   // does not sit behind a multiplier. The user must change configuration only
   // while the block is idle; the block itself does not enforce this.
   always_ff @(posedge clock) begin
      deadzone_sq_ff <= (2*RADIUS_W)'(deadzone_ff) * (2*RADIUS_W)'(deadzone_ff);
   end

   always_comb begin
      unique case (cfg_index)
         REG_DEADZONE:   prdata = 32'(deadzone_ff);
         REG_MAX_SPEED:  prdata = 32'(max_speed_ff);
         REG_FULL_SCALE: prdata = 32'(full_scale_ff);
         default:        prdata = 32'd0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Front stages: mixing, magnitudes, dead-zone test, numerators, divisor.
   // The pipeline never stalls, so an item is taken whenever start is high
   // outside reset.
   // ---------------------------------------------------------------------
   logic take;

   assign busy = reset;
   assign take = start && !busy;

   ctrl_type           chain_ctrl    [SPEED_W+1];
   logic [NUM_W-1:0]   chain_rem_r   [SPEED_W+1];
   logic [NUM_W-1:0]   chain_rem_l   [SPEED_W+1];
   logic [SPEED_W-1:0] chain_quo_r   [SPEED_W+1];
   logic [SPEED_W-1:0] chain_quo_l   [SPEED_W+1];
   logic [DIV_W-1:0]   chain_divisor [SPEED_W+1];

   jddm_front #(
      .AXIS_BITS (AXIS_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .stick_x     (req_stick_x),
      .stick_y     (req_stick_y),
      .deadzone_sq (deadzone_sq_ff),
      .max_speed   (max_speed_ff),
      .full_scale  (full_scale_ff),
      .dn_ctrl     (chain_ctrl[0]),
      .dn_num_r    (chain_rem_r[0]),
      .dn_num_l    (chain_rem_l[0]),
      .dn_divisor  (chain_divisor[0])
   );

   assign chain_quo_r[0] = '0;
   assign chain_quo_l[0] = '0;

   // ---------------------------------------------------------------------
   // Divider chain. Because each magnitude never exceeds the divisor and
   // max speed fits in seven bits, the quotient fits in seven bits, so the
   // first cell starts at the top quotient bit. Each cell compares against
   // the divisor shifted to its bit, subtracts when it fits and passes the
   // partial remainder and quotient on to its neighbor.
   // ---------------------------------------------------------------------
   for (genvar g = 0; g < SPEED_W; g++) begin : g_cell
      jddm_div_cell #(
         .NUM_W   (NUM_W),
         .DIV_W   (DIV_W),
         .BIT_POS (SPEED_W - 1 - g)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .up_ctrl    (chain_ctrl[g]),
         .up_rem_r   (chain_rem_r[g]),
         .up_rem_l   (chain_rem_l[g]),
         .up_quo_r   (chain_quo_r[g]),
         .up_quo_l   (chain_quo_l[g]),
         .up_divisor (chain_divisor[g]),
         .dn_ctrl    (chain_ctrl[g+1]),
         .dn_rem_r   (chain_rem_r[g+1]),
         .dn_rem_l   (chain_rem_l[g+1]),
         .dn_quo_r   (chain_quo_r[g+1]),
         .dn_quo_l   (chain_quo_l[g+1]),
         .dn_divisor (chain_divisor[g+1])
      );
   end

   // ---------------------------------------------------------------------
   // Output register. Inside the dead zone both motors stop. Otherwise the
   // direction follows the sign of the mix, except that a speed which
   // truncates to zero reports stop.
   // ---------------------------------------------------------------------
   ctrl_type           last_ctrl;
   logic [SPEED_W-1:0] last_quo_r, last_quo_l;
   logic [SPEED_W-1:0] right_speed_in, left_speed_in;
   dir_type            right_dir_in, left_dir_in;
   logic               valid_ff, dead_ff;
   logic [SPEED_W-1:0] right_speed_ff, left_speed_ff;
   dir_type            right_dir_ff, left_dir_ff;

   assign last_ctrl  = chain_ctrl[SPEED_W];
   assign last_quo_r = chain_quo_r[SPEED_W];
   assign last_quo_l = chain_quo_l[SPEED_W];

   always_comb begin
      right_speed_in = last_ctrl.dead ? '0 : last_quo_r;
      left_speed_in  = last_ctrl.dead ? '0 : last_quo_l;
      if (right_speed_in == '0) begin
         right_dir_in = DIR_STOP;
      end else if (last_ctrl.neg_r) begin
         right_dir_in = DIR_BACK;
      end else begin
         right_dir_in = DIR_FWD;
      end
      if (left_speed_in == '0) begin
         left_dir_in = DIR_STOP;
      end else if (last_ctrl.neg_l) begin
         left_dir_in = DIR_BACK;
      end else begin
         left_dir_in = DIR_FWD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= last_ctrl.valid;
      end
      dead_ff        <= last_ctrl.dead;
      right_speed_ff <= right_speed_in;
      left_speed_ff  <= left_speed_in;
      right_dir_ff   <= right_dir_in;
      left_dir_ff    <= left_dir_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_in_deadzone = dead_ff;
   assign rsp_right_speed = right_speed_ff;
   assign rsp_left_speed  = left_speed_ff;
   assign rsp_right_dir   = right_dir_ff;
   assign rsp_left_dir    = left_dir_ff;

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------

   // Every item taken reaches the result port, and nothing else does.
   a_latency : assert property (@(posedge clock) disable iff (reset)
      take |-> ##10 rsp_valid)
      else $error("accepted item did not reach the result port on time");

   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(take, 10))
      else $error("result strobe without a matching accepted item");

   // A speed of zero and the stop direction go together on both motors.
   a_dir_speed : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (((rsp_right_speed == '0) == (rsp_right_dir == DIR_STOP)) &&
                     ((rsp_left_speed == '0) == (rsp_left_dir == DIR_STOP))))
      else $error("direction disagrees with speed");

   // The divider can never produce more than the configured top speed.
   a_speed_cap : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_right_speed <= max_speed_ff) &&
                     (rsp_left_speed <= max_speed_ff)))
      else $error("speed above the configured maximum");

endmodule

`default_nettype wire
